/* hdl/dwg_bitcode_packer_core_defines.svh */
// assertion macros for the bit-code packer
`ifndef DWG_BITCODE_PACKER_CORE_DEFINES_SVH
`define DWG_BITCODE_PACKER_CORE_DEFINES_SVH

// same-cycle implication
`define DWGBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DWGBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/dwgbp_pkg.sv */
package dwgbp_pkg;

    localparam int CODE_W = 72;
    localparam int BUF_W  = CODE_W + 8;

    typedef enum logic [3:0] {
        CMD_BIT    = 4'd0,
        CMD_BIT2   = 4'd1,
        CMD_BIT3   = 4'd2,
        CMD_BYTE   = 4'd3,
        CMD_RAW16  = 4'd4,
        CMD_RAW32  = 4'd5,
        CMD_RAW64  = 4'd6,
        CMD_BSHORT = 4'd7,
        CMD_BLONG  = 4'd8,
        CMD_BLL    = 4'd9,
        CMD_BDBL   = 4'd10,
        CMD_HANDLE = 4'd11,
        CMD_POS    = 4'd12,
        CMD_PAD    = 4'd13
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [63:0] value;
        logic [3:0]  ref_type;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       overflow;
    } out_item_t;

    // code bits left aligned, msb goes out first
    typedef struct packed {
        logic [CODE_W-1:0] bits;
        logic [6:0]        len;
        logic              overflow;
    } code_t;

endpackage

/* hdl/dwgbp_encoder.sv */
module dwgbp_encoder
    import dwgbp_pkg::*;
(
    input  in_item_t   item,
    input  logic [2:0] offset,
    output code_t      code
);

    logic [63:0] v;
    logic [63:0] sw;
    logic [63:0] bll_mask;
    logic [63:0] hv;
    logic [3:0]  nsig;
    logic [6:0]  nbits;
    logic [2:0]  pad_len;

    function automatic logic [63:0] le_order(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[63-8*i -: 8] = x[8*i +: 8];
        end
        return r;
    endfunction

    function automatic logic [15:0] le16(input logic [15:0] x);
        return {x[7:0], x[15:8]};
    endfunction

    function automatic logic [3:0] sig_bytes(input logic [63:0] x);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (x[8*i +: 8] != 8'd0)
            begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    assign v        = item.value;
    assign sw       = le_order(v);
    assign nsig     = sig_bytes(v);
    assign nbits    = {nsig, 3'b000};
    assign bll_mask = ~({64{1'b1}} >> nbits);
    assign hv       = v << (7'd64 - nbits);
    assign pad_len  = 3'd0 - offset;

    always_comb
    begin
        code = '0;
        unique case (item.cmd)
            CMD_BIT:
            begin
                code.bits = {v[0], 71'b0};
                code.len  = 7'd1;
            end
            CMD_BIT2:
            begin
                code.bits = {v[1:0], 70'b0};
                code.len  = 7'd2;
            end
            CMD_BIT3:
            begin
                code.bits = {v[2:0], 69'b0};
                code.len  = 7'd3;
            end
            CMD_BYTE:
            begin
                code.bits = {v[7:0], 64'b0};
                code.len  = 7'd8;
            end
            CMD_RAW16:
            begin
                code.bits = {sw[63:48], 56'b0};
                code.len  = 7'd16;
            end
            CMD_RAW32:
            begin
                code.bits = {sw[63:32], 40'b0};
                code.len  = 7'd32;
            end
            CMD_RAW64:
            begin
                code.bits = {sw, 8'b0};
                code.len  = 7'd64;
            end
            CMD_BSHORT:
            begin
                if (v[15:0] == 16'd0)
                begin
                    code.bits = {2'b10, 70'b0};
                    code.len  = 7'd2;
                end
                else if (v[15:8] == 8'd0)
                begin
                    code.bits = {2'b01, v[7:0], 62'b0};
                    code.len  = 7'd10;
                end
                else if (v[15:0] == 16'd256)
                begin
                    code.bits = {2'b11, 70'b0};
                    code.len  = 7'd2;
                end
                else
                begin
                    code.bits = {2'b00, le16(v[15:0]), 54'b0};
                    code.len  = 7'd18;
                end
            end
            CMD_BLONG:
            begin
                if (v[31:0] == 32'd0)
                begin
                    code.bits = {2'b10, 70'b0};
                    code.len  = 7'd2;
                end
                else if (v[31:8] == 24'd0)
                begin
                    code.bits = {2'b01, v[7:0], 62'b0};
                    code.len  = 7'd10;
                end
                else
                begin
                    code.bits = {2'b00, sw[63:32], 38'b0};
                    code.len  = 7'd34;
                end
            end
            CMD_BLL:
            begin
                if (nsig[3])
                begin
                    code.overflow = 1'b1;
                    code.len      = 7'd3;
                end
                else
                begin
                    code.bits = {nsig[2:0], sw & bll_mask, 5'b0};
                    code.len  = nbits + 7'd3;
                end
            end
            CMD_BDBL:
            begin
                if (v[62:0] == 63'd0)
                begin
                    code.bits = {2'b10, 70'b0};
                    code.len  = 7'd2;
                end
                else if (v == 64'h3FF0_0000_0000_0000)
                begin
                    code.bits = {2'b01, 70'b0};
                    code.len  = 7'd2;
                end
                else
                begin
                    code.bits = {2'b00, sw, 6'b0};
                    code.len  = 7'd66;
                end
            end
            CMD_HANDLE:
            begin
                code.bits = {item.ref_type, nsig, hv};
                code.len  = nbits + 7'd8;
            end
            CMD_POS:
            begin
                if (!v[63] && v[62:15] != 48'd0)
                begin
                    if (v[62:30] != 33'd0)
                    begin
                        code.bits = {le16(v[45:30]), le16({1'b1, v[29:15]}),
                                     le16({1'b1, v[14:0]}), 24'b0};
                        code.len  = 7'd48;
                    end
                    else
                    begin
                        code.bits = {le16(v[30:15]), le16({1'b1, v[14:0]}), 40'b0};
                        code.len  = 7'd32;
                    end
                end
                else
                begin
                    code.bits = {le16(v[15:0]), 56'b0};
                    code.len  = 7'd16;
                end
            end
            CMD_PAD:
            begin
                code.len = {4'b0, pad_len};
            end
            default:
            begin
                code = '0;
            end
        endcase
    end

endmodule

/* hdl/dwg_bitcode_packer_core.sv */
// dwg bit-code packer
// input channel (in_valid, in_stall, in_data) takes one command item: cmd,
// value and ref_type. the item's code is appended msb first to a partial
// byte kept between items; every byte that fills up leaves on the output
// channel (out_valid, out_stall, out_data) as one item with last set on the
// final byte of that command and overflow set for a dropped bitlonglong.
// on taking an item its code is merged with the partial byte in
// an 80-bit shift register, which then drains one byte per cycle while out_stall
// is low, the first offered in the cycle after the item is taken. an item that
// completes n bytes (n = 0..9) holds the input stalled until its last byte
// has left. items that complete no byte leave the block idle and can
// follow each other without a gap.
// the output item is taken straight from the shift register, so a stall on
// the output freezes the byte, the count and the input side.
// reset clears the partial byte and bit offset to zero and leaves the block
// idle with no output pending.
module dwg_bitcode_packer_core
    import dwgbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

`include "dwg_bitcode_packer_core_defines.svh"

    state_t            state_reg, state_next;
    logic [2:0]        offset_reg, offset_next;
    logic [7:0]        partial_reg, partial_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic              ovf_reg, ovf_next;

    code_t             code;
    logic [BUF_W-1:0]  merged;
    logic [6:0]        total;

    dwgbp_encoder u_encoder (
        .item   (in_data),
        .offset (offset_reg),
        .code   (code)
    );

    assign merged = {partial_reg, {CODE_W{1'b0}}} | ({code.bits, 8'b0} >> offset_reg);
    assign total  = {4'b0, offset_reg} + code.len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            offset_reg  <= 3'd0;
            partial_reg <= 8'd0;
            cnt_reg     <= 4'd0;
        end
        else
        begin
            state_reg   <= state_next;
            offset_reg  <= offset_next;
            partial_reg <= partial_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        ovf_reg <= ovf_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        offset_next  = offset_reg;
        partial_next = partial_reg;
        cnt_next     = cnt_reg;
        buf_next     = buf_reg;
        ovf_next     = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    offset_next = total[2:0];
                    if (total[6:3] == 4'd0)
                    begin
                        partial_next = merged[BUF_W-1 -: 8];
                    end
                    else
                    begin
                        buf_next   = merged;
                        cnt_next   = total[6:3];
                        ovf_next   = code.overflow;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    buf_next = buf_reg << 8;
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        partial_next = buf_reg[BUF_W-9 -: 8];
                        state_next   = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall          = (state_reg == ST_EMIT);
    assign out_valid         = (state_reg == ST_EMIT);
    assign out_data.out_byte = buf_reg[BUF_W-1 -: 8];
    assign out_data.last     = (cnt_reg == 4'd1);
    assign out_data.overflow = ovf_reg;

    `DWGBP_ASSERT_NOW(a_cnt_range, out_valid, cnt_reg >= 4'd1 && cnt_reg <= 4'd9, "byte count out of range")
    `DWGBP_ASSERT_NOW(a_stall_while_emit, out_valid, in_stall, "input taken while bytes pending")
    `DWGBP_ASSERT_NEXT(a_last_ends, out_valid && !out_stall && out_data.last, !out_valid, "output continues after last item")

endmodule

/* sim/dwg_bitcode_packer_checker.sv */
module dwg_bitcode_packer_checker
    import dwgbp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        fail_count,
    output int        bytes_left
);
    timeunit 1ns;
    timeprecision 1ps;

    // predicted stream position
    int unsigned bit_fill;
    logic [7:0]  acc_byte;
    out_item_t   stream_bytes_due[$];

    task automatic put_bit(input logic b);
        if (b)
            acc_byte[7 - bit_fill] = 1'b1;
        bit_fill++;
        if (bit_fill == 8)
        begin
            stream_bytes_due.push_back('{out_byte: acc_byte, last: 1'b0, overflow: 1'b0});
            acc_byte = '0;
            bit_fill = 0;
        end
    endtask

    task automatic put_bits(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            put_bit(v[i]);
    endtask

    // little-endian bytes, each msb first
    task automatic put_le(input logic [63:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            put_bits(v >> (8 * i), 8);
    endtask

    function automatic int sig_byte_count(input logic [63:0] v);
        int n;
        n = 0;
        while (v != 0)
        begin
            v = v >> 8;
            n++;
        end
        return n;
    endfunction

    task automatic pack_command(input in_item_t it);
        int          first;
        int          n;
        logic        ovf;
        logic [63:0] v;
        first = stream_bytes_due.size();
        ovf = 1'b0;
        v = it.value;
        case (it.cmd)
            CMD_BIT:    put_bits(v, 1);
            CMD_BIT2:   put_bits(v, 2);
            CMD_BIT3:   put_bits(v, 3);
            CMD_BYTE:   put_le(v, 1);
            CMD_RAW16:  put_le(v, 2);
            CMD_RAW32:  put_le(v, 4);
            CMD_RAW64:  put_le(v, 8);
            CMD_BSHORT:
            begin
                if (v[15:0] == 16'd0)
                    put_bits(64'd2, 2);
                else if (v[15:0] < 16'd256)
                begin
                    put_bits(64'd1, 2);
                    put_le(v, 1);
                end
                else if (v[15:0] == 16'd256)
                    put_bits(64'd3, 2);
                else
                begin
                    put_bits(64'd0, 2);
                    put_le(v, 2);
                end
            end
            CMD_BLONG:
            begin
                if (v[31:0] == 32'd0)
                    put_bits(64'd2, 2);
                else if (v[31:0] < 32'd256)
                begin
                    put_bits(64'd1, 2);
                    put_le(v, 1);
                end
                else
                begin
                    put_bits(64'd0, 2);
                    put_le(v, 4);
                end
            end
            CMD_BLL:
            begin
                n = sig_byte_count(v);
                if (n >= 8)
                begin
                    ovf = 1'b1;
                    put_bits(64'd0, 3);
                end
                else
                begin
                    put_bits(64'(n), 3);
                    put_le(v, n);
                end
            end
            CMD_BDBL:
            begin
                if (v[62:0] == 63'd0)
                    put_bits(64'd2, 2);
                else if (v == 64'h3FF0_0000_0000_0000)
                    put_bits(64'd1, 2);
                else
                begin
                    put_bits(64'd0, 2);
                    put_le(v, 8);
                end
            end
            CMD_HANDLE:
            begin
                n = sig_byte_count(v);
                put_bits(64'({it.ref_type, n[3:0]}), 8);
                for (int k = n; k > 0; k--)
                    put_bits(v >> (8 * (k - 1)), 8);
            end
            CMD_POS:
            begin
                if (!v[63] && v >= 64'h8000)
                begin
                    if (v >= 64'h4000_0000)
                    begin
                        put_le(64'(v[45:30]), 2);
                        put_le(64'({1'b1, v[29:15]}), 2);
                    end
                    else
                        put_le(64'(v[30:15]), 2);
                    put_le(64'({1'b1, v[14:0]}), 2);
                end
                else
                    put_le(64'(v[15:0]), 2);
            end
            CMD_PAD:
            begin
                while (bit_fill != 0)
                    put_bit(1'b0);
            end
            default: ;
        endcase
        for (int k = first; k < stream_bytes_due.size(); k++)
            stream_bytes_due[k].overflow = ovf;
        if (stream_bytes_due.size() > first)
            stream_bytes_due[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            bit_fill = 0;
            acc_byte = '0;
            stream_bytes_due.delete();
            fail_count = 0;
            bytes_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (stream_bytes_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("packer check: unexpected byte %h last %b overflow %b",
                                 out_data.out_byte, out_data.last, out_data.overflow);
                end
                else
                begin
                    want = stream_bytes_due.pop_front();
                    if (out_data.out_byte !== want.out_byte || out_data.last !== want.last
                        || out_data.overflow !== want.overflow)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("packer check: got %h/%b/%b want %h/%b/%b",
                                     out_data.out_byte, out_data.last, out_data.overflow,
                                     want.out_byte, want.last, want.overflow);
                    end
                end
            end
            if (in_valid && !in_stall)
                pack_command(in_data);
            bytes_left <= stream_bytes_due.size();
        end
    end

endmodule

/* sim/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dwgbp_pkg::*;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd14;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam int         RANDOM_PER_PHASE = 120;
    localparam int         HOLD_CYCLES = 300;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    int fail_count;
    int bytes_left;
    int tx_idle_pct = 6;
    int rx_idle_pct = 51;
    bit hold_req = 1'b0;

    dwg_bitcode_packer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    dwg_bitcode_packer_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .bytes_left (bytes_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("dwg_bitcode_packer_core: mismatch");
        $finish;
    end

    // receiver side, with one long hold-off to back the block up
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    function automatic in_item_t cmd_item(input logic [3:0] c, input logic [63:0] v,
                                          input logic [3:0] rt);
        in_item_t it;
        it.cmd = c;
        it.value = v;
        it.ref_type = rt;
        return it;
    endfunction

    function automatic in_item_t random_cmd_item();
        logic [3:0]  c;
        logic [63:0] v;
        int          pick;
        if ($urandom_range(99) < 4)
            c = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        else
            c = 4'($urandom_range(CMD_BIT, CMD_PAD));
        v = {$urandom, $urandom};
        pick = $urandom_range(3);
        case (c)
            CMD_BSHORT:
            begin
                if (pick == 0)
                    v[15:0] = 16'd0;
                else if (pick == 1)
                    v[15:0] = 16'($urandom_range(1, 255));
                else if (pick == 2)
                    v[15:0] = 16'd256;
            end
            CMD_BLONG:
            begin
                if (pick == 0)
                    v[31:0] = 32'd0;
                else if (pick == 1)
                    v[31:0] = $urandom_range(1, 255);
            end
            CMD_BLL, CMD_HANDLE:
                v = v >> $urandom_range(0, 64);
            CMD_BDBL:
            begin
                if (pick == 0)
                    v = {v[63], 63'd0};
                else if (pick == 1)
                    v = 64'h3FF0_0000_0000_0000;
            end
            CMD_POS:
            begin
                if (pick != 3)
                    v = v >> $urandom_range(1, 63);
            end
            default: ;
        endcase
        return cmd_item(c, v, 4'($urandom_range(0, 15)));
    endfunction

    task automatic offer(input in_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        in_item_t it;
        int       taken;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // three partial codes leave the offset at six, so the dropped
        // bitlonglong completes a byte and its overflow shows
        offer(cmd_item(CMD_BIT, 64'd1, 4'd0));
        offer(cmd_item(CMD_BIT2, 64'd3, 4'd0));
        offer(cmd_item(CMD_BIT3, 64'd5, 4'd0));
        offer(cmd_item(CMD_BLL, 64'h0100_0000_0000_0000, 4'd0));
        offer(cmd_item(CMD_BYTE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0));
        offer(cmd_item(CMD_PAD, 64'd0, 4'd0));
        offer(cmd_item(CMD_PAD, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15));
        offer(cmd_item(CMD_BYTE, 64'hA5, 4'd0));
        offer(cmd_item(CMD_RAW16, 64'h1234, 4'd0));
        offer(cmd_item(CMD_RAW32, 64'hDEAD_BEEF, 4'd0));
        offer(cmd_item(CMD_RAW64, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0));
        offer(cmd_item(CMD_BSHORT, 64'd0, 4'd0));
        offer(cmd_item(CMD_BSHORT, 64'hFFFF_FFFF_FFFF_007F, 4'd0));
        offer(cmd_item(CMD_BSHORT, 64'd256, 4'd0));
        offer(cmd_item(CMD_BSHORT, 64'hFFFF, 4'd0));
        offer(cmd_item(CMD_BLONG, 64'd0, 4'd0));
        offer(cmd_item(CMD_BLONG, 64'd255, 4'd0));
        offer(cmd_item(CMD_BLONG, 64'hFFFF_FFFF, 4'd0));
        offer(cmd_item(CMD_BLL, 64'd0, 4'd0));
        offer(cmd_item(CMD_BLL, 64'h00FF_FFFF_FFFF_FFFF, 4'd0));
        offer(cmd_item(CMD_BDBL, 64'd0, 4'd0));
        offer(cmd_item(CMD_BDBL, 64'h8000_0000_0000_0000, 4'd0));
        offer(cmd_item(CMD_BDBL, 64'h3FF0_0000_0000_0000, 4'd0));
        offer(cmd_item(CMD_HANDLE, 64'd0, 4'd15));
        offer(cmd_item(CMD_HANDLE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0));
        offer(cmd_item(CMD_POS, 64'h7FFF, 4'd0));
        offer(cmd_item(CMD_POS, 64'h8000, 4'd0));
        offer(cmd_item(CMD_POS, 64'h3FFF_FFFF, 4'd0));
        offer(cmd_item(CMD_POS, 64'h4000_0000, 4'd0));
        offer(cmd_item(CMD_POS, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0));
        offer(cmd_item(CMD_UNUSED_LO, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15));
        offer(cmd_item(CMD_UNUSED_HI, 64'd1, 4'd1));

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                tx_idle_pct = 51;
                rx_idle_pct = 6;
            end
            else if (phase == 2)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_req = 1'b1;
            end
            taken = 0;
            while (taken < RANDOM_PER_PHASE)
            begin
                it = random_cmd_item();
                offer(it);
                if (it.cmd <= CMD_PAD)
                    taken++;
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (bytes_left != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("dwg_bitcode_packer_core: match");
        else
            $display("dwg_bitcode_packer_core: mismatch");
        $finish;
    end

endmodule

/* dwg_bitcode_packer_core.f */
+incdir+hdl
hdl/dwgbp_pkg.sv
hdl/dwgbp_encoder.sv
hdl/dwg_bitcode_packer_core.sv
sim/dwg_bitcode_packer_checker.sv
sim/testbench.sv
